// ----- src/ring_buffer_moving_average_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the ring buffer moving average block
// Both forms sample on the rising edge of clk and are off while rst is high.
// ---------------------------------------------------------------------------
`ifndef RING_BUFFER_MOVING_AVERAGE_ASSERT_SVH
`define RING_BUFFER_MOVING_AVERAGE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RBMA_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbma: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RBMA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbma: next-cycle check failed");

`endif

// ----- src/rbma_pkg.sv -----
// ---------------------------------------------------------------------------
// rbma_pkg
// Shared sizes, mode codes and the divider request type.
// ---------------------------------------------------------------------------
package rbma_pkg;

  localparam int MAX_SLOTS        = 64;
  localparam int SAMPLE_BITS      = 32;
  localparam int SLOT_BITS        = $clog2(MAX_SLOTS);
  localparam int COUNT_BITS       = $clog2(MAX_SLOTS + 1);
  localparam int TOTAL_BITS       = SAMPLE_BITS + SLOT_BITS;
  localparam int DIV_STEP_BITS    = $clog2(TOTAL_BITS + 1);
  localparam int CFG_BITS         = 7;
  localparam int SLOT_COUNT_RESET = 4;
  localparam int MODE_BITS        = 2;
  localparam int IN_DATA_BITS     = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_RAW_BITS     = 2 * SAMPLE_BITS + COUNT_BITS;
  localparam int OUT_DATA_BITS    = ((OUT_RAW_BITS + 7) / 8) * 8;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef logic [MODE_BITS-1:0] mode_t;

  localparam mode_t MODE_RECORD = 2'd0;
  localparam mode_t MODE_RESET  = 2'd1;
  localparam mode_t MODE_FLUSH  = 2'd2;

  typedef struct packed {
    logic                          start;
    logic signed [TOTAL_BITS-1:0]  dividend;
    logic        [COUNT_BITS-1:0]  divisor;
  } div_req_t;

endpackage

// ----- src/rbma_ram.sv -----
// ---------------------------------------------------------------------------
// rbma_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module rbma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/rbma_div.sv -----
// ---------------------------------------------------------------------------
// rbma_div
// Restoring divider: signed total by unsigned count, one quotient bit per
// cycle, truncated toward zero and saturated to the sample width.
// ---------------------------------------------------------------------------
module rbma_div (
  input  logic                                      clk,
  input  logic                                      rst,
  input  rbma_pkg::div_req_t                        req,
  output logic                                      done,
  output logic signed [rbma_pkg::SAMPLE_BITS-1:0]   quotient
);

  logic                                  busy;
  logic [rbma_pkg::DIV_STEP_BITS-1:0]    steps;
  logic                                  neg;
  logic [rbma_pkg::COUNT_BITS-1:0]       divisor;
  logic [rbma_pkg::COUNT_BITS-1:0]       rem;
  logic [rbma_pkg::TOTAL_BITS-1:0]       quo;
  logic [rbma_pkg::TOTAL_BITS-1:0]       mag;
  logic [rbma_pkg::COUNT_BITS:0]         trial;
  logic [rbma_pkg::COUNT_BITS:0]         trial_diff;
  logic                                  fits;
  logic                                  high_clear;
  logic signed [rbma_pkg::SAMPLE_BITS-1:0] sat_result;

  // Magnitude of the dividend; the most negative total maps to its own
  // unsigned pattern, which is the correct magnitude.
  assign mag = req.dividend[rbma_pkg::TOTAL_BITS-1] ? -req.dividend : req.dividend;

  assign trial      = {rem, quo[rbma_pkg::TOTAL_BITS-1]};
  assign trial_diff = trial - {1'b0, divisor};
  assign fits       = (trial >= {1'b0, divisor});

  assign high_clear = (quo[rbma_pkg::TOTAL_BITS-1:rbma_pkg::SAMPLE_BITS-1] == '0);

  always_comb begin
    if (!high_clear) begin
      sat_result = neg ? rbma_pkg::SAMPLE_MIN : rbma_pkg::SAMPLE_MAX;
    end else if (neg) begin
      sat_result = -$signed(quo[rbma_pkg::SAMPLE_BITS-1:0]);
    end else begin
      sat_result = $signed(quo[rbma_pkg::SAMPLE_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // pulse done for one cycle once the last quotient bit is in
      done <= !req.start && busy && (steps == '0);
      if (req.start) begin
        busy    <= 1'b1;
        steps   <= rbma_pkg::DIV_STEP_BITS'(rbma_pkg::TOTAL_BITS);
        neg     <= req.dividend[rbma_pkg::TOTAL_BITS-1];
        divisor <= req.divisor;
        rem     <= '0;
        quo     <= mag;
      end else if (busy) begin
        if (steps == '0) begin
          busy     <= 1'b0;
          quotient <= sat_result;
        end else begin
          // shift one dividend bit into the remainder, subtract if it fits
          rem   <= fits ? trial_diff[rbma_pkg::COUNT_BITS-1:0]
                        : trial[rbma_pkg::COUNT_BITS-1:0];
          quo   <= {quo[rbma_pkg::TOTAL_BITS-2:0], fits};
          steps <= steps - 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/ring_buffer_moving_average.sv -----
// ---------------------------------------------------------------------------
// ring_buffer_moving_average
// Moving average over a ring of signed Q16.16 samples held in one RAM.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per beat: tuser is the mode (record, reset
//   fill, flush fill), tdata the Q16.16 value. m_axis returns exactly one
//   result beat per command: average, last recorded value and sample count.
//   cfg_wr_en / cfg_wr_data load slot_count (0 acts as 1, above 64 as 64);
//   write it only while no command is in flight.
// Sequencing (one command in flight at a time):
//   record  : the result waits on the bit-serial divider (one quotient
//             bit per cycle over the 38-bit total).
//   reset / flush : one RAM write per active slot.
//   unused mode   : one RAM read for the last value.
// The sample RAM has one write and one registered read port; a record reads
// the oldest slot, then writes the new sample over it in the next cycle.
// Reset: slot_count returns to 4, count, total, average and write slot clear,
//   and per-slot valid bits mark the whole ring as zero at once.
// Stall: the result sits in an output register; the next command waits in
//   the emit step until that register drains.
// ---------------------------------------------------------------------------
`include "ring_buffer_moving_average_assert.svh"

module ring_buffer_moving_average (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write: slot_count
  input  logic                                  cfg_wr_en,
  input  logic [rbma_pkg::CFG_BITS-1:0]         cfg_wr_data,
  // command stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [rbma_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,  // [31:0] value
  input  logic [rbma_pkg::MODE_BITS-1:0]        s_axis_tuser,  // [1:0] mode
  // result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [31:0] average, [63:32] last_value, [70:64] sample_count, [71] zero
  output logic [rbma_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_READ   = 6'b000010,
    S_MODIFY = 6'b000100,
    S_FILL   = 6'b001000,
    S_DIV    = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t state;

  // architectural state
  logic [rbma_pkg::CFG_BITS-1:0]            slot_count;
  logic [rbma_pkg::SLOT_BITS-1:0]           ws;
  logic [rbma_pkg::COUNT_BITS-1:0]          count;
  logic signed [rbma_pkg::TOTAL_BITS-1:0]   total;
  logic signed [rbma_pkg::SAMPLE_BITS-1:0]  avg_held;
  logic                                     valid [rbma_pkg::MAX_SLOTS];

  // per-command working registers
  rbma_pkg::mode_t                          mode_reg;
  logic signed [rbma_pkg::SAMPLE_BITS-1:0]  value_reg;
  logic [rbma_pkg::COUNT_BITS-1:0]          n_reg;
  logic [rbma_pkg::COUNT_BITS-1:0]          fill_idx;
  logic [rbma_pkg::SLOT_BITS-1:0]           rd_addr;
  logic                                     rd_valid;
  logic signed [rbma_pkg::SAMPLE_BITS-1:0]  last_reg;
  logic                                     div_start;

  // output register
  logic                                     out_valid;
  logic signed [rbma_pkg::SAMPLE_BITS-1:0]  out_avg;
  logic signed [rbma_pkg::SAMPLE_BITS-1:0]  out_last;
  logic [rbma_pkg::COUNT_BITS-1:0]          out_count;

  // combinational
  rbma_pkg::mode_t                          mode_in;
  logic signed [rbma_pkg::SAMPLE_BITS-1:0]  in_value;
  logic [rbma_pkg::COUNT_BITS-1:0]          n_eff;
  logic [rbma_pkg::SLOT_BITS-1:0]           ws_eff;
  logic [rbma_pkg::COUNT_BITS-1:0]          cnt_eff;
  logic [rbma_pkg::SLOT_BITS-1:0]           peek_addr;
  logic signed [rbma_pkg::SAMPLE_BITS+rbma_pkg::COUNT_BITS:0] fill_prod;
  logic [rbma_pkg::SAMPLE_BITS-1:0]         ram_rdata;
  logic signed [rbma_pkg::SAMPLE_BITS-1:0]  old_sample;
  logic signed [rbma_pkg::TOTAL_BITS-1:0]   total_sum;
  logic [rbma_pkg::COUNT_BITS-1:0]          ws_inc;
  logic [rbma_pkg::SLOT_BITS-1:0]           ws_wrap;
  logic                                     fill_last;
  logic                                     is_record;
  logic                                     out_free;
  logic                                     ram_we;
  logic [rbma_pkg::SLOT_BITS-1:0]           ram_waddr;
  logic [rbma_pkg::COUNT_BITS-1:0]          wr_slot_ext;
  rbma_pkg::div_req_t                       div_req;
  logic                                     div_done;
  logic signed [rbma_pkg::SAMPLE_BITS-1:0]  div_quotient;

  assign mode_in  = s_axis_tuser;
  assign in_value = $signed(s_axis_tdata[rbma_pkg::SAMPLE_BITS-1:0]);

  // Active slot count: zero acts as one, anything above the ring depth clamps.
  always_comb begin
    if (slot_count == '0) begin
      n_eff = rbma_pkg::COUNT_BITS'(1);
    end else if (int'(slot_count) > rbma_pkg::MAX_SLOTS) begin
      n_eff = rbma_pkg::COUNT_BITS'(rbma_pkg::MAX_SLOTS);
    end else begin
      n_eff = rbma_pkg::COUNT_BITS'(slot_count);
    end
  end

  // Pull the write slot and count back inside a ring that may have shrunk.
  assign ws_eff    = (rbma_pkg::COUNT_BITS'(ws) >= n_eff) ? '0 : ws;
  assign cnt_eff   = (count > n_eff) ? n_eff : count;
  // Most recently written slot, for the unused mode's report.
  assign peek_addr = (ws_eff == '0) ? rbma_pkg::SLOT_BITS'(n_eff - 1'b1)
                                    : ws_eff - 1'b1;

  // Fill total: value times active slots, wrapped to the total width.
  assign fill_prod = in_value * $signed({1'b0, n_eff});

  // Slots never written since reset read as zero.
  assign old_sample = rd_valid ? $signed(ram_rdata) : '0;
  assign total_sum  = total + rbma_pkg::TOTAL_BITS'(value_reg)
                            - rbma_pkg::TOTAL_BITS'(old_sample);

  assign ws_inc    = rbma_pkg::COUNT_BITS'(ws) + 1'b1;
  assign ws_wrap   = (ws_inc >= n_reg) ? '0 : ws_inc[rbma_pkg::SLOT_BITS-1:0];
  assign fill_last = ((fill_idx + 1'b1) == n_reg);
  assign is_record = (mode_reg == rbma_pkg::MODE_RECORD);
  assign out_free  = !out_valid || m_axis_tready;

  // RAM write: every step of a fill, or the single write-back of a record.
  assign ram_we      = (state == S_FILL) || ((state == S_MODIFY) && is_record);
  assign ram_waddr   = (state == S_FILL) ? fill_idx[rbma_pkg::SLOT_BITS-1:0] : ws;
  assign wr_slot_ext = rbma_pkg::COUNT_BITS'(ram_waddr);

  rbma_ram #(
    .WIDTH (rbma_pkg::SAMPLE_BITS),
    .DEPTH (rbma_pkg::MAX_SLOTS)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (value_reg),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Divide the registered total by the registered count.
  assign div_req.start    = div_start;
  assign div_req.dividend = total;
  assign div_req.divisor  = count;

  rbma_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = rbma_pkg::OUT_DATA_BITS'({out_count, out_last, out_avg});

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_count <= rbma_pkg::CFG_BITS'(rbma_pkg::SLOT_COUNT_RESET);
      ws         <= '0;
      count      <= '0;
      total      <= '0;
      avg_held   <= '0;
      div_start  <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < rbma_pkg::MAX_SLOTS; i++) begin
        valid[i] <= 1'b0;
      end
    end else begin
      // start the divider right after a record's write-back
      div_start <= (state == S_MODIFY) && is_record;
      if (cfg_wr_en) begin
        slot_count <= cfg_wr_data;
      end
      if ((state == S_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            // commit the wrapped slot and clamped count for every mode
            ws    <= ws_eff;
            count <= cnt_eff;
            if (mode_in inside {rbma_pkg::MODE_RESET, rbma_pkg::MODE_FLUSH}) begin
              total <= fill_prod[rbma_pkg::TOTAL_BITS-1:0];
              state <= S_FILL;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_MODIFY;
        end
        S_MODIFY: begin
          if (is_record) begin
            total     <= total_sum;
            valid[ws] <= 1'b1;
            ws        <= ws_wrap;
            if (count < n_reg) begin
              count <= count + 1'b1;
            end
            state     <= S_DIV;
          end else begin
            state <= S_EMIT;
          end
        end
        S_FILL: begin
          valid[fill_idx[rbma_pkg::SLOT_BITS-1:0]] <= 1'b1;
          if (fill_last) begin
            if (mode_reg == rbma_pkg::MODE_FLUSH) begin
              count    <= n_reg;
              avg_held <= value_reg;
            end else begin
              count <= '0;
            end
            state <= S_EMIT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            avg_held <= div_quotient;
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          // hold here until the output register can take the result
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk) begin
    rd_valid <= valid[rd_addr];
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          mode_reg  <= mode_in;
          value_reg <= in_value;
          n_reg     <= n_eff;
          fill_idx  <= '0;
          rd_addr   <= (mode_in == rbma_pkg::MODE_RECORD) ? ws_eff : peek_addr;
        end
      end
      S_MODIFY: begin
        if (is_record) begin
          last_reg <= value_reg;
        end else begin
          last_reg <= (count != '0) ? old_sample : '0;
        end
      end
      S_FILL: begin
        fill_idx <= fill_idx + 1'b1;
        if (fill_last) begin
          last_reg <= (mode_reg == rbma_pkg::MODE_FLUSH) ? value_reg : '0;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_avg   <= avg_held;
          out_last  <= last_reg;
          out_count <= count;
        end
      end
      default: begin
      end
    endcase
  end

  // The divider never sees a zero count.
  `RBMA_ASSERT_IMPLY(a_div_count_nonzero, state == S_DIV, count != '0)
  // RAM writes stay inside the active ring.
  `RBMA_ASSERT_IMPLY(a_write_in_ring, ram_we, wr_slot_ext < n_reg)
  // Only one command is in flight: accepting drops ready on the next cycle.
  `RBMA_ASSERT_NEXT(a_single_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

// ----- sim/ring_buffer_moving_average_tb.sv -----
// ---------------------------------------------------------------------------
// ring_buffer_moving_average_tb
// Self-checking bench for the ring buffer moving average. Commands go in on
// s_axis and results are scored against an in-bench model of the ring, the
// running total and the average. A directed table covers the extremes, all
// modes and the slot count corner cases. Random phases follow, each with its
// own slot count, with random stalls on both streams outside one steady phase.
// ---------------------------------------------------------------------------
module ring_buffer_moving_average_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Mode code the block does not define: it must report without updating.
  localparam rbma_pkg::mode_t MODE_UNUSED = 2'd3;
  localparam int    CYCLE_LIMIT   = 1_000_000;
  localparam int    RANDOM_ITEMS  = 1000;
  localparam int    PHASE_ITEMS   = 100;
  localparam int    STEADY_PHASE  = 5;
  localparam int    DRAIN_CYCLES  = 60;
  localparam int    IDLE_PERCENT  = 37;

  // One result beat. Packed so that it lines up with m_axis_tdata[70:0]:
  // average in the low word, then last_value, then sample_count.
  typedef struct packed {
    logic [rbma_pkg::COUNT_BITS-1:0]         sample_count;
    logic signed [rbma_pkg::SAMPLE_BITS-1:0] last_value;
    logic signed [rbma_pkg::SAMPLE_BITS-1:0] average;
  } avg_result_t;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  // One line of the directed table. Rows marked typed carry a hand-written
  // result; the rest are scored against the model.
  typedef struct {
    row_kind_t       kind;
    rbma_pkg::mode_t mode;
    logic [31:0]     value;
    bit              typed;
    avg_result_t     want;
  } stim_row_t;

  logic                                 clk = 1'b0;
  logic                                 rst;
  logic                                 cfg_wr_en;
  logic [rbma_pkg::CFG_BITS-1:0]        cfg_wr_data;
  logic                                 s_axis_tvalid;
  logic                                 s_axis_tready;
  logic [rbma_pkg::IN_DATA_BITS-1:0]    s_axis_tdata;   // [31:0] value
  logic [rbma_pkg::MODE_BITS-1:0]       s_axis_tuser;   // [1:0] mode
  logic                                 m_axis_tvalid;
  logic                                 m_axis_tready;
  // [31:0] average, [63:32] last_value, [70:64] sample_count, [71] zero
  logic [rbma_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata;

  // Model of the block: ring contents, write pointer, count, total, average.
  logic signed [rbma_pkg::SAMPLE_BITS-1:0] ring_img [rbma_pkg::MAX_SLOTS];
  int unsigned                             next_slot;
  int unsigned                             held_count;
  logic signed [rbma_pkg::TOTAL_BITS-1:0]  sum_img;
  logic signed [rbma_pkg::SAMPLE_BITS-1:0] avg_img;
  logic [rbma_pkg::CFG_BITS-1:0]           slot_count_img;

  avg_result_t pending_results[$];
  stim_row_t   directed[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          steady = 1'b0;

  ring_buffer_moving_average u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Step the model by one command and return the beat it should produce.
  function automatic avg_result_t predict_average(rbma_pkg::mode_t m,
                                                  logic signed [31:0] v);
    int unsigned n;
    longint      quo;
    avg_result_t r;
    // Zero acts as one slot, anything above the ring size as the full ring.
    if (slot_count_img == 0) n = 1;
    else if (slot_count_img > rbma_pkg::MAX_SLOTS) n = rbma_pkg::MAX_SLOTS;
    else n = 32'(slot_count_img);
    // A lowered slot count wraps the pointer and clips the count first.
    if (next_slot >= n) next_slot = 0;
    if (held_count > n) held_count = n;
    case (m)
      rbma_pkg::MODE_RECORD: begin
        if (held_count < n) held_count++;
        // The total wraps at its own width, same as the hardware register.
        sum_img = sum_img + v - ring_img[rbma_pkg::SLOT_BITS'(next_slot)];
        ring_img[rbma_pkg::SLOT_BITS'(next_slot)] = v;
        next_slot++;
        // Signed division truncates toward zero; then clamp to 32 bits.
        quo = longint'(sum_img) / longint'(held_count);
        if (quo > longint'(rbma_pkg::SAMPLE_MAX)) avg_img = rbma_pkg::SAMPLE_MAX;
        else if (quo < longint'(rbma_pkg::SAMPLE_MIN)) avg_img = rbma_pkg::SAMPLE_MIN;
        else avg_img = quo[rbma_pkg::SAMPLE_BITS-1:0];
        if (next_slot >= n) next_slot = 0;
      end
      rbma_pkg::MODE_RESET, rbma_pkg::MODE_FLUSH: begin
        // Fill only the active slots; the write pointer stays put.
        for (int i = 0; i < n; i++) ring_img[i] = v;
        sum_img = rbma_pkg::TOTAL_BITS'(longint'(v) * longint'(n));
        if (m == rbma_pkg::MODE_FLUSH) begin
          held_count = n;
          avg_img = v;
        end else begin
          held_count = 0;
        end
      end
      default: ;
    endcase
    r.average = avg_img;
    if (held_count != 0)
      r.last_value = ring_img[rbma_pkg::SLOT_BITS'((next_slot == 0) ? n - 1 : next_slot - 1)];
    else r.last_value = '0;
    r.sample_count = rbma_pkg::COUNT_BITS'(held_count);
    return r;
  endfunction

  function automatic void add_row(row_kind_t kind, rbma_pkg::mode_t m, logic [31:0] v,
                                  bit typed = 1'b0, logic [31:0] avg = '0,
                                  logic [31:0] last = '0, logic [6:0] cnt = '0);
    stim_row_t row;
    row.kind  = kind;
    row.mode  = m;
    row.value = v;
    row.typed = typed;
    row.want.average      = avg;
    row.want.last_value   = last;
    row.want.sample_count = cnt;
    directed.push_back(row);
  endfunction

  // Draw a sample: mostly full-range, often small values near zero, and
  // now and then one of the extremes.
  function automatic logic [31:0] random_sample();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0: return rbma_pkg::SAMPLE_MAX;
          1: return rbma_pkg::SAMPLE_MIN;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      1, 2: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  // Present one command beat, hold it until accepted, then log its result.
  // Called right after a rising edge; assigns tvalid once per time step.
  task automatic send_beat(rbma_pkg::mode_t m, logic [31:0] v, bit typed,
                           avg_result_t want);
    avg_result_t predicted;
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tuser  <= m;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = predict_average(m, v);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Load slot_count only once the block has gone quiet.
  task automatic write_slot_count(logic [rbma_pkg::CFG_BITS-1:0] c);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    slot_count_img = c;
  endtask

  // Result side: stall at random except during the steady phase.
  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Score every accepted result beat against the oldest expectation.
  always @(posedge clk) begin
    avg_result_t got;
    avg_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(avg_result_t)-1:0];
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: %h", m_axis_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.average !== want.average) begin
          $error("average: expected %h, actual %h", want.average, got.average);
          error_count++;
        end
        if (got.last_value !== want.last_value) begin
          $error("last_value: expected %h, actual %h", want.last_value, got.last_value);
          error_count++;
        end
        if (got.sample_count !== want.sample_count) begin
          $error("sample_count: expected %0d, actual %0d",
                 want.sample_count, got.sample_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog: give up if the run hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ring_buffer_moving_average_tb: FAIL");
      $finish;
    end
  end

  initial begin
    rbma_pkg::mode_t               m;
    int unsigned                   pick;
    logic [rbma_pkg::CFG_BITS-1:0] sweep [5];
    avg_result_t                   none;

    // Drive every input to a known value before the first edge.
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    none          = '0;

    // Model state after reset.
    for (int i = 0; i < rbma_pkg::MAX_SLOTS; i++) ring_img[i] = '0;
    next_slot      = 0;
    held_count     = 0;
    sum_img        = '0;
    avg_img        = '0;
    slot_count_img = rbma_pkg::CFG_BITS'(rbma_pkg::SLOT_COUNT_RESET);

    // Directed table. Slot count starts at its reset value of four.
    // Unused mode straight after reset reports all zeros.
    add_row(ROW_BEAT, MODE_UNUSED, 32'h1234_5678, 1'b1, 32'h0, 32'h0, 7'd0);
    // Largest positive samples: the average sits at the top of the range.
    add_row(ROW_BEAT, rbma_pkg::MODE_RECORD, rbma_pkg::SAMPLE_MAX, 1'b1,
            rbma_pkg::SAMPLE_MAX, rbma_pkg::SAMPLE_MAX, 7'd1);
    add_row(ROW_BEAT, rbma_pkg::MODE_RECORD, rbma_pkg::SAMPLE_MAX, 1'b1,
            rbma_pkg::SAMPLE_MAX, rbma_pkg::SAMPLE_MAX, 7'd2);
    add_row(ROW_BEAT, rbma_pkg::MODE_RECORD, rbma_pkg::SAMPLE_MIN);
    add_row(ROW_BEAT, rbma_pkg::MODE_RECORD, rbma_pkg::SAMPLE_MIN);
    add_row(ROW_BEAT, rbma_pkg::MODE_RECORD, rbma_pkg::SAMPLE_MIN);
    // One more record, with the write pointer already wrapped past slot zero.
    add_row(ROW_BEAT, rbma_pkg::MODE_RECORD, 32'h0000_0001);
    // Reset fill: count drops to zero, average stays.
    add_row(ROW_BEAT, rbma_pkg::MODE_RESET, 32'h0001_0000);
    add_row(ROW_BEAT, rbma_pkg::MODE_RECORD, 32'h0003_0000);
    add_row(ROW_BEAT, rbma_pkg::MODE_FLUSH, rbma_pkg::SAMPLE_MIN, 1'b1,
            rbma_pkg::SAMPLE_MIN, rbma_pkg::SAMPLE_MIN, 7'd4);
    add_row(ROW_BEAT, MODE_UNUSED, 32'h0000_0000);
    add_row(ROW_BEAT, rbma_pkg::MODE_FLUSH, 32'h0000_0000, 1'b1, 32'h0, 32'h0, 7'd4);
    // Total of -1 over four: truncation toward zero gives 0, not -1.
    add_row(ROW_BEAT, rbma_pkg::MODE_RECORD, 32'hFFFF_FFFF);
    add_row(ROW_BEAT, rbma_pkg::MODE_FLUSH, rbma_pkg::SAMPLE_MAX, 1'b1,
            rbma_pkg::SAMPLE_MAX, rbma_pkg::SAMPLE_MAX, 7'd4);
    // Slot count of zero acts as a single slot.
    add_row(ROW_CFG, rbma_pkg::MODE_RECORD, 32'd0);
    add_row(ROW_BEAT, rbma_pkg::MODE_RECORD, 32'h0002_0000);
    add_row(ROW_BEAT, rbma_pkg::MODE_RECORD, 32'hFFFE_0000);
    // Above the ring size saturates to the full ring.
    add_row(ROW_CFG, rbma_pkg::MODE_RECORD, 32'd127);
    add_row(ROW_BEAT, rbma_pkg::MODE_FLUSH, rbma_pkg::SAMPLE_MAX, 1'b1,
            rbma_pkg::SAMPLE_MAX, rbma_pkg::SAMPLE_MAX, 7'd64);
    add_row(ROW_BEAT, rbma_pkg::MODE_RECORD, 32'h5555_AAAA);
    add_row(ROW_BEAT, rbma_pkg::MODE_RECORD, 32'hAAAA_5555);
    add_row(ROW_BEAT, rbma_pkg::MODE_RECORD, 32'h8000_0001);
    // Lower the slot count while the pointer sits past the new end.
    add_row(ROW_CFG, rbma_pkg::MODE_RECORD, 32'd3);
    add_row(ROW_BEAT, rbma_pkg::MODE_RECORD, 32'h7FFF_FFFE);
    // Fill the full ring at the top, then shrink to one slot and swing the
    // sample from min to max.
    add_row(ROW_CFG, rbma_pkg::MODE_RECORD, 32'd64);
    add_row(ROW_BEAT, rbma_pkg::MODE_FLUSH, rbma_pkg::SAMPLE_MAX, 1'b1,
            rbma_pkg::SAMPLE_MAX, rbma_pkg::SAMPLE_MAX, 7'd64);
    add_row(ROW_CFG, rbma_pkg::MODE_RECORD, 32'd1);
    add_row(ROW_BEAT, rbma_pkg::MODE_RECORD, rbma_pkg::SAMPLE_MIN);
    add_row(ROW_BEAT, rbma_pkg::MODE_RECORD, rbma_pkg::SAMPLE_MAX);
    add_row(ROW_BEAT, rbma_pkg::MODE_RECORD, rbma_pkg::SAMPLE_MAX);

    // Hold reset, then release it for good.
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG)
        write_slot_count(directed[i].value[rbma_pkg::CFG_BITS-1:0]);
      else
        send_beat(directed[i].mode, directed[i].value, directed[i].typed, directed[i].want);
    end

    // Random phases, each under its own slot count. The first few sweep the
    // corners; the rest draw any 7-bit value, mostly inside the valid range.
    sweep[0] = 7'd1;
    sweep[1] = 7'd64;
    sweep[2] = 7'd0;
    sweep[3] = 7'd127;
    sweep[4] = 7'd2;
    for (int p = 0; p < RANDOM_ITEMS / PHASE_ITEMS; p++) begin
      if (p < 5) write_slot_count(sweep[p]);
      else if ($urandom_range(0, 3) == 0)
        write_slot_count(rbma_pkg::CFG_BITS'($urandom_range(0, 127)));
      else write_slot_count(rbma_pkg::CFG_BITS'($urandom_range(1, 16)));
      // One phase runs with no idling on either stream.
      steady = (p == STEADY_PHASE);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 78) m = rbma_pkg::MODE_RECORD;
        else if (pick < 86) m = rbma_pkg::MODE_RESET;
        else if (pick < 94) m = rbma_pkg::MODE_FLUSH;
        else m = MODE_UNUSED;
        send_beat(m, random_sample(), 1'b0, none);
      end
    end

    // Drain: wait for every result, then let the block settle.
    s_axis_tvalid <= 1'b0;
    steady = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("ring_buffer_moving_average_tb: PASS");
    end else begin
      $display("ring_buffer_moving_average_tb: FAIL");
    end
    $finish;
  end

endmodule
